// File: rtl/pxb_pkg.sv
package pxb_pkg;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    localparam logic       FUNC_QUERY  = 1'b0;
    localparam logic       FUNC_APPEND = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam int VALUE_W  = 30;
    localparam int BOUND_W  = 10;
    localparam int FILLED_W = 11;

endpackage

// File: rtl/prefix_xor_basis_range_max.sv
// Range maximum-XOR over an append-only sequence. Each stored position keeps
// a full WIDTH-row basis snapshot in one DEPTH*WIDTH-entry single-port-write
// memory; rows carry the newest supporting position. An accepted append or
// query walks the WIDTH rows from the top bit down, one row per cycle through
// the registered memory read, first through ST_SETUP and then ST_RUN, with busy
// high until done. A refused item (store full, or upper bound not yet filled)
// never leaves idle: busy stays low and done is raised straight from idle.
// The result is on answer/status/filled for exactly one cycle with done high;
// it cannot be stalled. The memory has no reset and no clearing pass: only
// written snapshots are ever used.
module prefix_xor_basis_range_max #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [WIDTH-1:0]               value,
    input  logic [$clog2(DEPTH)-1:0]       left,
    input  logic [$clog2(DEPTH)-1:0]       right,
    output logic                           done,
    output logic [WIDTH-1:0]               answer,
    output logic [1:0]                     status,
    output logic [$clog2(DEPTH+1)-1:0]     filled
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);
    localparam int AW = $clog2(DEPTH * WIDTH);
    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int MW = WIDTH + PW;

    pxb_pkg::state_t state_reg, state_next;

    logic                          func_reg, func_next;
    logic [WIDTH-1:0]              v_reg, v_next;
    logic [WIDTH-1:0]              r_reg, r_next;
    logic [PW-1:0]                 cur_reg, cur_next;
    logic                          stop_reg, stop_next;
    logic                          first_reg, first_next;
    logic [PW-1:0]                 at_reg, at_next;
    logic [PW-1:0]                 snap_reg, snap_next;
    logic [PW-1:0]                 lo_reg, lo_next;
    logic [FW-1:0]                 fill_reg, fill_next;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;
    logic [AW-1:0]                 wr_addr_reg, wr_addr_next;
    logic [IW-1:0]                 cnt_reg, cnt_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic                          iss_reg, iss_next;
    logic                          proc_reg, proc_next;
    logic                          done_reg, done_next;
    logic [WIDTH-1:0]              answer_reg, answer_next;
    logic [1:0]                    status_reg, status_next;
    logic [FW-1:0]                 filled_reg, filled_next;

    logic [MW-1:0]                 mem [DEPTH*WIDTH];
    logic [MW-1:0]                 mem_q;
    logic                          wr_en;
    logic [MW-1:0]                 wr_data;

    logic [PW-1:0]                 lo_in, hi_in;
    logic [WIDTH-1:0]              old_row;
    logic [PW-1:0]                 old_pos;
    logic [WIDTH-1:0]              new_row;
    logic [PW-1:0]                 new_pos;
    logic [WIDTH-1:0]              v_step;
    logic [WIDTH-1:0]              r_step;
    logic [PW-1:0]                 cur_step;
    logic                          stop_step;

    assign busy   = (state_reg != pxb_pkg::ST_IDLE);
    assign done   = done_reg;
    assign answer = answer_reg;
    assign status = status_reg;
    assign filled = filled_reg;

    assign lo_in = (left > right) ? right : left;
    assign hi_in = (left > right) ? left : right;

    assign old_row = first_reg ? '0 : mem_q[WIDTH-1:0];
    assign old_pos = first_reg ? '0 : mem_q[MW-1:WIDTH];

    // one basis row per cycle
    always_comb
    begin
        new_row   = old_row;
        new_pos   = old_pos;
        v_step    = v_reg;
        cur_step  = cur_reg;
        stop_step = stop_reg;
        r_step    = r_reg;
        if (func_reg == pxb_pkg::FUNC_APPEND)
        begin
            if (!stop_reg && v_reg[idx_reg])
            begin
                if (old_row == '0)
                begin
                    new_row   = v_reg;
                    new_pos   = cur_reg;
                    stop_step = 1'b1;
                end
                else if (old_pos <= cur_reg)
                begin
                    new_row  = v_reg;
                    new_pos  = cur_reg;
                    v_step   = v_reg ^ old_row;
                    cur_step = old_pos;
                end
                else
                begin
                    v_step = v_reg ^ old_row;
                end
            end
        end
        else
        begin
            if ((old_pos >= lo_reg) && ((r_reg ^ old_row) > r_reg))
            begin
                r_step = r_reg ^ old_row;
            end
        end
    end

    assign wr_en   = proc_reg && (func_reg == pxb_pkg::FUNC_APPEND);
    assign wr_data = {new_pos, new_row};

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        v_next       = v_reg;
        r_next       = r_reg;
        cur_next     = cur_reg;
        stop_next    = stop_reg;
        first_next   = first_reg;
        at_next      = at_reg;
        snap_next    = snap_reg;
        lo_next      = lo_reg;
        fill_next    = fill_reg;
        rd_addr_next = rd_addr_reg;
        wr_addr_next = wr_addr_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        iss_next     = 1'b0;
        proc_next    = 1'b0;
        done_next    = 1'b0;
        answer_next  = answer_reg;
        status_next  = status_reg;
        filled_next  = filled_reg;

        case (state_reg)
            pxb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    v_next    = value;
                    lo_next   = lo_in;
                    r_next    = '0;
                    stop_next = 1'b0;
                    at_next   = PW'(fill_reg);
                    cur_next  = PW'(fill_reg);
                    first_next = (fill_reg == '0);
                    if (func == pxb_pkg::FUNC_APPEND)
                    begin
                        snap_next = (fill_reg == '0) ? '0 : PW'(fill_reg - 1'b1);
                        if (fill_reg >= FW'(DEPTH))
                        begin
                            done_next   = 1'b1;
                            answer_next = '0;
                            status_next = pxb_pkg::STATUS_FULL;
                            filled_next = fill_reg;
                        end
                        else
                        begin
                            state_next = pxb_pkg::ST_SETUP;
                        end
                    end
                    else
                    begin
                        snap_next  = hi_in;
                        first_next = 1'b0;
                        if (FW'(hi_in) >= fill_reg)
                        begin
                            done_next   = 1'b1;
                            answer_next = '0;
                            status_next = pxb_pkg::STATUS_RANGE;
                            filled_next = fill_reg;
                        end
                        else
                        begin
                            state_next = pxb_pkg::ST_SETUP;
                        end
                    end
                end
            end

            pxb_pkg::ST_SETUP:
            begin
                rd_addr_next = AW'(snap_reg) * AW'(WIDTH) + AW'(WIDTH - 1);
                wr_addr_next = AW'(at_reg) * AW'(WIDTH) + AW'(WIDTH - 1);
                cnt_next     = IW'(WIDTH - 1);
                iss_next     = 1'b1;
                state_next   = pxb_pkg::ST_RUN;
            end

            pxb_pkg::ST_RUN:
            begin
                if (iss_reg)
                begin
                    rd_addr_next = rd_addr_reg - 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    iss_next     = (cnt_reg != '0);
                    idx_next     = cnt_reg;
                    proc_next    = 1'b1;
                end
                if (proc_reg)
                begin
                    v_next       = v_step;
                    r_next       = r_step;
                    cur_next     = cur_step;
                    stop_next    = stop_step;
                    wr_addr_next = wr_addr_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next  = pxb_pkg::ST_IDLE;
                        done_next   = 1'b1;
                        status_next = pxb_pkg::STATUS_OK;
                        if (func_reg == pxb_pkg::FUNC_APPEND)
                        begin
                            answer_next = '0;
                            fill_next   = fill_reg + 1'b1;
                            filled_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            answer_next = r_step;
                            filled_next = fill_reg;
                        end
                    end
                end
            end

            default:
            begin
                state_next = pxb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pxb_pkg::ST_IDLE;
            fill_reg  <= '0;
            iss_reg   <= 1'b0;
            proc_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            iss_reg   <= iss_next;
            proc_reg  <= proc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        v_reg       <= v_next;
        r_reg       <= r_next;
        cur_reg     <= cur_next;
        stop_reg    <= stop_next;
        first_reg   <= first_next;
        at_reg      <= at_next;
        snap_reg    <= snap_next;
        lo_reg      <= lo_next;
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        answer_reg  <= answer_next;
        status_reg  <= status_next;
        filled_reg  <= filled_next;
    end

    // snapshot store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr_reg] <= wr_data;
        end
        if (iss_reg)
        begin
            mem_q <= mem[rd_addr_reg];
        end
    end

endmodule

// File: verif/tb_prefix_xor_basis_range_max.sv
`timescale 1ns / 1ps

module tb_prefix_xor_basis_range_max;

    localparam int WIDTH = 30;
    localparam int DEPTH = 1024;
    localparam int VALUE_W = pxb_pkg::VALUE_W;
    localparam int BOUND_W = pxb_pkg::BOUND_W;
    localparam int FILLED_W = pxb_pkg::FILLED_W;
    localparam int DIR_ROWS = 22;
    localparam int TAIL_ITEMS = 300;
    localparam int QUIET_ITEMS = 100;

    typedef struct packed {
        logic [VALUE_W-1:0]  answer;
        logic [1:0]          status;
        logic [FILLED_W-1:0] filled;
    } xor_reply_t;

    typedef struct packed {
        logic                func;
        logic [VALUE_W-1:0]  value;
        logic [BOUND_W-1:0]  left;
        logic [BOUND_W-1:0]  right;
        logic                typed;
        logic [VALUE_W-1:0]  answer;
        logic [1:0]          status;
        logic [FILLED_W-1:0] filled;
    } stim_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                func = pxb_pkg::FUNC_QUERY;
    logic [VALUE_W-1:0]  value = '0;
    logic [BOUND_W-1:0]  left = '0;
    logic [BOUND_W-1:0]  right = '0;
    logic                busy;
    logic                done;
    logic [VALUE_W-1:0]  answer;
    logic [1:0]          status;
    logic [FILLED_W-1:0] filled;

    // predictor state: one WIDTH-row snapshot per stored position
    logic [VALUE_W-1:0]  basis_row_mem [0:DEPTH*WIDTH-1];
    logic [BOUND_W-1:0]  basis_pos_mem [0:DEPTH*WIDTH-1];
    int                  stored_count;

    xor_reply_t          reply_fifo [0:15];
    int                  reply_wr = 0;
    int                  reply_rd = 0;
    xor_reply_t          oldest_reply;
    int                  mismatch_count = 0;
    int                  idle_pct = 25;
    logic [VALUE_W-1:0]  value_pool [0:7];
    stim_row_t           dir_rows [0:DIR_ROWS-1];

    prefix_xor_basis_range_max #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .func   (func),
        .value  (value),
        .left   (left),
        .right  (right),
        .done   (done),
        .answer (answer),
        .status (status),
        .filled (filled)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic xor_reply_t predict_reply(input logic f, input logic [VALUE_W-1:0] v,
                                                 input logic [BOUND_W-1:0] l,
                                                 input logic [BOUND_W-1:0] r);
        xor_reply_t         res;
        int                 base;
        int                 i;
        logic               placed;
        logic [VALUE_W-1:0] vec;
        logic [VALUE_W-1:0] old_row;
        logic [VALUE_W-1:0] acc;
        logic [BOUND_W-1:0] cur;
        logic [BOUND_W-1:0] old_pos;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        res = '0;
        res.status = pxb_pkg::STATUS_OK;
        if (f == pxb_pkg::FUNC_APPEND)
        begin
            if (stored_count >= DEPTH)
                res.status = pxb_pkg::STATUS_FULL;
            else
            begin
                base = stored_count * WIDTH;
                cur = stored_count[BOUND_W-1:0];
                vec = v;
                placed = 1'b0;
                for (i = 0; i < WIDTH; i++)
                begin
                    if (stored_count == 0)
                    begin
                        basis_row_mem[base+i] = '0;
                        basis_pos_mem[base+i] = '0;
                    end
                    else
                    begin
                        basis_row_mem[base+i] = basis_row_mem[base-WIDTH+i];
                        basis_pos_mem[base+i] = basis_pos_mem[base-WIDTH+i];
                    end
                end
                // newer positions win: swap the incoming vector into older rows
                for (i = WIDTH - 1; i >= 0; i--)
                begin
                    if (!placed && vec[i])
                    begin
                        if (basis_row_mem[base+i] == '0)
                        begin
                            basis_row_mem[base+i] = vec;
                            basis_pos_mem[base+i] = cur;
                            placed = 1'b1;
                        end
                        else if (basis_pos_mem[base+i] <= cur)
                        begin
                            old_row = basis_row_mem[base+i];
                            old_pos = basis_pos_mem[base+i];
                            basis_row_mem[base+i] = vec;
                            basis_pos_mem[base+i] = cur;
                            vec = vec ^ old_row;
                            cur = old_pos;
                        end
                        else
                            vec = vec ^ basis_row_mem[base+i];
                    end
                end
                stored_count++;
            end
        end
        else
        begin
            lo = (l > r) ? r : l;
            hi = (l > r) ? l : r;
            if (int'(hi) >= stored_count)
                res.status = pxb_pkg::STATUS_RANGE;
            else
            begin
                base = int'(hi) * WIDTH;
                acc = '0;
                for (i = WIDTH - 1; i >= 0; i--)
                begin
                    if (basis_pos_mem[base+i] >= lo && (acc ^ basis_row_mem[base+i]) > acc)
                        acc = acc ^ basis_row_mem[base+i];
                end
                res.answer = acc;
            end
        end
        res.filled = stored_count[FILLED_W-1:0];
        return res;
    endfunction

    task automatic issue_item(input logic f, input logic [VALUE_W-1:0] v,
                              input logic [BOUND_W-1:0] l, input logic [BOUND_W-1:0] r,
                              input logic typed, input xor_reply_t typed_reply);
        xor_reply_t pred;
        func <= f;
        value <= v;
        left <= l;
        right <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pred = predict_reply(f, v, l, r);
        reply_fifo[reply_wr[3:0]] = typed ? typed_reply : pred;
        reply_wr++;
    endtask

    task automatic maybe_idle(input logic allow);
        if (allow && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 k;
        int                 sel;
        sel = $urandom_range(0, 99);
        v = '0;
        if (sel < 35)
            v = VALUE_W'($urandom);
        else if (sel < 60)
        begin
            // combinations of a small pool force reductions and swaps
            for (k = 0; k < 8; k++)
                if ($urandom_range(0, 1))
                    v = v ^ value_pool[k];
        end
        else if (sel < 72)
            v[$urandom_range(0, VALUE_W - 1)] = 1'b1;
        else if (sel < 80)
            v = VALUE_W'($urandom_range(0, 15));
        else if (sel < 86)
            v = '1;
        else if (sel < 90)
            v = '0;
        else
            v = VALUE_W'($urandom) >> $urandom_range(1, VALUE_W - 1);
        return v;
    endfunction

    task automatic random_item(input int append_pct, input logic allow_idle);
        logic [BOUND_W-1:0] l;
        logic [BOUND_W-1:0] r;
        logic [BOUND_W-1:0] t;
        int                 sel;
        l = BOUND_W'($urandom);
        r = BOUND_W'($urandom);
        if ($urandom_range(0, 99) < append_pct)
            issue_item(pxb_pkg::FUNC_APPEND, pick_value(), l, r, 1'b0, '0);
        else
        begin
            sel = $urandom_range(0, 99);
            if (stored_count == 0 || (stored_count < DEPTH && sel < 10))
                r = BOUND_W'($urandom_range(stored_count, DEPTH - 1));
            else
            begin
                r = BOUND_W'($urandom_range(0, stored_count - 1));
                if (sel < 55)
                    l = BOUND_W'($urandom_range(0, r));
                else if (sel < 75)
                    l = (r > 10'd3) ? r - BOUND_W'($urandom_range(0, 3)) : '0;
                else
                begin
                    t = BOUND_W'($urandom_range(0, r));
                    l = r;
                    r = t;
                end
            end
            issue_item(pxb_pkg::FUNC_QUERY, pick_value(), l, r, 1'b0, '0);
        end
        maybe_idle(allow_idle);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (reply_wr == reply_rd)
            begin
                mismatch_count++;
                $display("%0t: unexpected reply answer %h status %0d filled %0d",
                         $time, answer, status, filled);
            end
            else
            begin
                oldest_reply = reply_fifo[reply_rd[3:0]];
                reply_rd++;
                if (answer !== oldest_reply.answer)
                begin
                    mismatch_count++;
                    $display("%0t: answer expected %h actual %h",
                             $time, oldest_reply.answer, answer);
                end
                if (status !== oldest_reply.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_reply.status, status);
                end
                if (filled !== oldest_reply.filled)
                begin
                    mismatch_count++;
                    $display("%0t: filled expected %0d actual %0d",
                             $time, oldest_reply.filled, filled);
                end
            end
        end
    end

    initial
    begin
        int n;
        int guard;
        dir_rows = '{
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_RANGE, 11'd0},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd1023, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_RANGE,
             11'd0},
            {pxb_pkg::FUNC_APPEND, 30'h3FFFFFFF, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_OK,
             11'd1},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd0, 10'd0, 1'b1, 30'h3FFFFFFF, pxb_pkg::STATUS_OK,
             11'd1},
            {pxb_pkg::FUNC_APPEND, 30'h0, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_OK, 11'd2},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd1, 10'd1, 1'b1, 30'h0, pxb_pkg::STATUS_OK, 11'd2},
            {pxb_pkg::FUNC_APPEND, 30'h20000000, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_OK,
             11'd3},
            {pxb_pkg::FUNC_QUERY, 30'h3FFFFFFF, 10'd2, 10'd0, 1'b0, 30'h0, pxb_pkg::STATUS_OK,
             11'd0},
            {pxb_pkg::FUNC_APPEND, 30'h1, 10'd1023, 10'd1023, 1'b1, 30'h0, pxb_pkg::STATUS_OK,
             11'd4},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd3, 10'd3, 1'b1, 30'h1, pxb_pkg::STATUS_OK, 11'd4},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd0, 10'd3, 1'b0, 30'h0, pxb_pkg::STATUS_OK, 11'd0},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd0, 10'd4, 1'b1, 30'h0, pxb_pkg::STATUS_RANGE, 11'd4},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd4, 10'd1023, 1'b1, 30'h0, pxb_pkg::STATUS_RANGE,
             11'd4},
            {pxb_pkg::FUNC_APPEND, 30'h15555555, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_OK,
             11'd5},
            {pxb_pkg::FUNC_APPEND, 30'h2AAAAAAA, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_OK,
             11'd6},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd5, 10'd4, 1'b0, 30'h0, pxb_pkg::STATUS_OK, 11'd0},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd0, 10'd5, 1'b0, 30'h0, pxb_pkg::STATUS_OK, 11'd0},
            {pxb_pkg::FUNC_APPEND, 30'h2, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_OK, 11'd7},
            {pxb_pkg::FUNC_APPEND, 30'h3FFFFFFF, 10'd0, 10'd0, 1'b1, 30'h0, pxb_pkg::STATUS_OK,
             11'd8},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd7, 10'd2, 1'b0, 30'h0, pxb_pkg::STATUS_OK, 11'd0},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd1023, 10'd1023, 1'b1, 30'h0, pxb_pkg::STATUS_RANGE,
             11'd8},
            {pxb_pkg::FUNC_QUERY, 30'h0, 10'd6, 10'd7, 1'b0, 30'h0, pxb_pkg::STATUS_OK, 11'd0}
        };
        stored_count = 0;
        for (n = 0; n < 8; n++)
            value_pool[n] = VALUE_W'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (n = 0; n < DIR_ROWS; n++)
        begin
            issue_item(dir_rows[n].func, dir_rows[n].value, dir_rows[n].left,
                       dir_rows[n].right, dir_rows[n].typed,
                       {dir_rows[n].answer, dir_rows[n].status, dir_rows[n].filled});
            maybe_idle(1'b1);
        end

        // fill the store with mostly appends and in-range queries
        n = 0;
        while (stored_count < DEPTH)
        begin
            if (n % 64 == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            random_item(75, 1'b1);
            n++;
        end

        // full store: appends are refused, queries span the whole range
        for (n = 0; n < TAIL_ITEMS; n++)
        begin
            if (n % 64 == 0)
                idle_pct = $urandom_range(0, 40);
            random_item(35, n < TAIL_ITEMS - QUIET_ITEMS);
        end
        start <= 1'b0;

        guard = 0;
        while (reply_wr != reply_rd && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (WIDTH + 8) @(posedge clk);
        if (reply_wr != reply_rd)
        begin
            mismatch_count += reply_wr - reply_rd;
            $display("%0t: %0d replies never arrived", $time, reply_wr - reply_rd);
        end
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/pxb_pkg.sv
rtl/prefix_xor_basis_range_max.sv
verif/tb_prefix_xor_basis_range_max.sv
